>>> rtl/core/dmct_pkg.sv
// Shared types and constants of the direct-mapped cache tag model.
package dmct_pkg;

   // Access kinds carried in the request beat.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_FETCH = 2'd2;
   localparam logic [1:0] KIND_FLUSH = 2'd3;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_MODE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIFIED_SET_BITS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INST_SET_BITS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_SET_BITS    = 3'd4;

   // Reset values of the configuration registers.
   localparam logic       SPLIT_MODE_RESET  = 1'b0;
   localparam logic [3:0] OFFSET_BITS_RESET = 4'd4;
   localparam logic [3:0] SET_BITS_RESET    = 4'd8;

   // Block offset limits; a block holds at most 1024 words.
   localparam logic [3:0] OFFSET_MIN = 4'd2;
   localparam logic [3:0] OFFSET_MAX = 4'd12;
   localparam int         WORDS_W    = 11;
   localparam int         COUNT_W    = 32;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               cold_miss;
      logic               replaced;
      logic               dirty_victim;
      logic               class_is_inst;
      logic [COUNT_W-1:0] class_accesses;
      logic [COUNT_W-1:0] class_misses;
      logic [COUNT_W-1:0] class_replacements;
      logic [COUNT_W-1:0] fetch_words_total;
      logic [COUNT_W-1:0] copyback_words_total;
   } rsp_type;

   // Sequencer states: clearing pass, normal running, flush walk, flush tail.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   // Sequencer status towards the lookup path.
   typedef struct packed {
      logic busy;
      logic clearing;
      logic flush_rd;
      logic flush_data_v;
      logic flush_last;
   } seq_ctl_type;

   // One statistics event per cycle from the lookup path and the flush walk.
   typedef struct packed {
      logic               acc_valid;
      logic               is_inst;
      logic               hit;
      logic               cold;
      logic               repl;
      logic               dvict;
      logic               flush_dirty;
      logic               flush_emit;
      logic [WORDS_W-1:0] words;
   } stat_ev_type;

endpackage

>>> rtl/core/direct_mapped_cache_tag_model.sv
// Top level of the direct-mapped write-back cache tag model.
//
// Reads, writes and instruction fetches are taken one per cycle while busy is
// low: the line is read from its tag RAM in the acceptance cycle, checked and
// written back in the next, with the previous write forwarded when two accesses
// in a row hit the same line. Each result passes the lookup stage and response
// register to rsp_strobe, one per cycle; the receiver cannot stall them. A
// flush walks the 2^set_bits lines of the data (or unified) store, one per
// cycle through the data RAM read port, keeps busy high through the walk and
// its drain state and reports in the cycle after busy falls. After reset a
// clearing pass invalidates both tag RAMs, with busy high throughout;
// configuration writes are taken at any time but are meant for an idle block.
module direct_mapped_cache_tag_model #(
   parameter int MAX_SET_BITS = 10,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  dmct_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output dmct_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmct_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dmct_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dmct_pkg::*;

   localparam int ADDR_USED = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
   localparam int TAG_W     = ADDR_USED - 2;
   localparam int ENTRY_W   = TAG_W + 2;
   localparam int DEPTH     = 1 << MAX_SET_BITS;
   localparam int DIRTY_POS = TAG_W;
   localparam int VALID_POS = TAG_W + 1;
   localparam logic [4:0] SB_LIMIT = 5'(MAX_SET_BITS);

   // Clamp a set-bits register to the store depth.
   function automatic logic [3:0] clamp_sets(input logic [3:0] raw);
      logic [3:0] res;
      res = ({1'b0, raw} > SB_LIMIT) ? SB_LIMIT[3:0] : raw;
      return res;
   endfunction

   // Configuration registers.
   logic       split_ff;
   logic [3:0] offset_ff, uni_sb_ff, inst_sb_ff, data_sb_ff;

   // Lookup stage registers.
   logic                    s1_v_ff;
   logic [1:0]              s1_kind_ff;
   logic                    s1_inst_ff;
   logic                    s1_istore_ff;
   logic [MAX_SET_BITS-1:0] s1_idx_ff;
   logic [TAG_W-1:0]        s1_tag_ff;

   // Forwarding of the last write-back.
   logic                    fwd_v_ff;
   logic                    fwd_istore_ff;
   logic [MAX_SET_BITS-1:0] fwd_idx_ff;
   logic [ENTRY_W-1:0]      fwd_entry_ff;

   logic                    accept, acc_beat, flush_beat, is_inst_req, use_istore;
   logic [3:0]              ob_eff, sb_req, sb_flush;
   logic [4:0]              tag_shift;
   logic [ADDR_USED-1:0]    addr_m, addr_idx_sh, addr_tag_sh;
   logic [MAX_SET_BITS-1:0] idx_req, last_set, walk_addr;
   logic [TAG_W-1:0]        tag_req;
   logic [WORDS_W-1:0]      words_now;
   seq_ctl_type             ctl;

   logic [ENTRY_W-1:0]      inst_rd, data_rd, old_entry, new_entry;
   logic                    old_valid, old_dirty, lk_hit, fwd_match;
   logic                    inst_we, data_we;
   logic [MAX_SET_BITS-1:0] wr_addr, data_rd_addr;
   logic [ENTRY_W-1:0]      wr_entry;
   stat_ev_type             ev;

   // Configuration port.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff   <= SPLIT_MODE_RESET;
         offset_ff  <= OFFSET_BITS_RESET;
         uni_sb_ff  <= SET_BITS_RESET;
         inst_sb_ff <= SET_BITS_RESET;
         data_sb_ff <= SET_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPLIT_MODE:       split_ff   <= csr_wdata[0];
            CSR_OFFSET_BITS:      offset_ff  <= csr_wdata;
            CSR_UNIFIED_SET_BITS: uni_sb_ff  <= csr_wdata;
            CSR_INST_SET_BITS:    inst_sb_ff <= csr_wdata;
            CSR_DATA_SET_BITS:    data_sb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Geometry of the current configuration and address split of the beat.
   always_comb begin
      accept      = start && !busy;
      flush_beat  = accept && (req_data.kind == KIND_FLUSH);
      acc_beat    = accept && (req_data.kind != KIND_FLUSH);
      is_inst_req = (req_data.kind == KIND_FETCH);
      use_istore  = split_ff && is_inst_req;

      if (offset_ff < OFFSET_MIN)      ob_eff = OFFSET_MIN;
      else if (offset_ff > OFFSET_MAX) ob_eff = OFFSET_MAX;
      else                             ob_eff = offset_ff;
      words_now = WORDS_W'(1) << (ob_eff - OFFSET_MIN);

      sb_req   = split_ff ? clamp_sets(is_inst_req ? inst_sb_ff : data_sb_ff)
                          : clamp_sets(uni_sb_ff);
      sb_flush = split_ff ? clamp_sets(data_sb_ff) : clamp_sets(uni_sb_ff);
      last_set = ~({MAX_SET_BITS{1'b1}} << sb_flush);

      addr_m      = req_data.address[ADDR_USED-1:0];
      tag_shift   = {1'b0, ob_eff} + {1'b0, sb_req};
      addr_idx_sh = addr_m >> ob_eff;
      addr_tag_sh = addr_m >> tag_shift;
      idx_req     = addr_idx_sh[MAX_SET_BITS-1:0]
                    & ~({MAX_SET_BITS{1'b1}} << sb_req);
      tag_req     = addr_tag_sh[TAG_W-1:0];
   end

   // Sequencer for clearing and flushing.
   dmct_seq #(
      .MAX_SET_BITS(MAX_SET_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .flush_start(flush_beat),
      .last_set   (last_set),
      .walk_addr  (walk_addr),
      .ctl        (ctl)
   );

   assign busy = ctl.busy;

   // Lookup stage capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= acc_beat;
         fwd_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_beat) begin
         s1_kind_ff   <= req_data.kind;
         s1_inst_ff   <= is_inst_req;
         s1_istore_ff <= use_istore;
         s1_idx_ff    <= idx_req;
         s1_tag_ff    <= tag_req;
      end
      fwd_istore_ff <= s1_istore_ff;
      fwd_idx_ff    <= s1_idx_ff;
      fwd_entry_ff  <= new_entry;
   end

   // Tag check and line update; the last write-back is forwarded.
   always_comb begin
      fwd_match = fwd_v_ff && (fwd_istore_ff == s1_istore_ff)
                  && (fwd_idx_ff == s1_idx_ff);
      old_entry = fwd_match ? fwd_entry_ff : (s1_istore_ff ? inst_rd : data_rd);
      old_valid = old_entry[VALID_POS];
      old_dirty = old_entry[DIRTY_POS];
      lk_hit    = old_valid && (old_entry[TAG_W-1:0] == s1_tag_ff);
      new_entry = {1'b1, (s1_kind_ff == KIND_WRITE) | (lk_hit & old_dirty), s1_tag_ff};
   end

   // RAM write and read port selection.
   always_comb begin
      wr_addr      = ctl.clearing ? walk_addr : s1_idx_ff;
      wr_entry     = ctl.clearing ? '0 : new_entry;
      inst_we      = ctl.clearing || (s1_v_ff && s1_istore_ff);
      data_we      = ctl.clearing || (s1_v_ff && !s1_istore_ff);
      data_rd_addr = ctl.flush_rd ? walk_addr : idx_req;
   end

   dmct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_inst_ram (
      .clock  (clock),
      .wr_en  (inst_we),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (acc_beat),
      .rd_addr(idx_req),
      .rd_data(inst_rd)
   );

   dmct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (data_we),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (acc_beat || ctl.flush_rd),
      .rd_addr(data_rd_addr),
      .rd_data(data_rd)
   );

   // Statistics event of this cycle.
   always_comb begin
      ev.acc_valid   = s1_v_ff;
      ev.is_inst     = s1_v_ff & s1_inst_ff;
      ev.hit         = lk_hit;
      ev.cold        = !old_valid;
      ev.repl        = old_valid && !lk_hit;
      ev.dvict       = old_valid && !lk_hit && old_dirty;
      ev.flush_dirty = ctl.flush_data_v && data_rd[DIRTY_POS];
      ev.flush_emit  = ctl.flush_data_v && ctl.flush_last;
      ev.words       = words_now;
   end

   dmct_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .ev        (ev),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/dmct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dmct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/dmct_seq.sv
// Sequencer for the clearing pass after reset and the flush walk.
module dmct_seq #(
   parameter int MAX_SET_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      flush_start,
   input  logic [MAX_SET_BITS-1:0]   last_set,
   output logic [MAX_SET_BITS-1:0]   walk_addr,
   output dmct_pkg::seq_ctl_type     ctl
);
   import dmct_pkg::*;

   localparam logic [MAX_SET_BITS-1:0] LAST_LINE = '1;

   state_type                 state_ff, state_in;
   logic [MAX_SET_BITS-1:0]   walk_ff, walk_in;
   logic                      data_v_ff, data_v_in;
   logic                      last_ff, last_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (walk_ff == LAST_LINE) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (flush_start) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (walk_ff == last_set) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Walk counter and the flags that follow each flush read in the next cycle.
   always_comb begin
      case (state_ff)
         ST_CLEAR, ST_FLUSH: walk_in = walk_ff + 1'b1;
         default:            walk_in = '0;
      endcase
      data_v_in = (state_ff == ST_FLUSH);
      last_in   = (state_ff == ST_FLUSH) && (walk_ff == last_set);
   end

   // Outputs.
   always_comb begin
      ctl.busy         = (state_ff != ST_RUN);
      ctl.clearing     = (state_ff == ST_CLEAR);
      ctl.flush_rd     = (state_ff == ST_FLUSH);
      ctl.flush_data_v = data_v_ff;
      ctl.flush_last   = last_ff;
      walk_addr        = walk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         walk_ff   <= '0;
         data_v_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         data_v_ff <= data_v_in;
         last_ff   <= last_in;
      end
   end

endmodule

>>> rtl/core/dmct_stats.sv
// Access, miss, replacement and word counters with the registered response.
module dmct_stats (
   input  logic                   clock,
   input  logic                   reset,
   input  dmct_pkg::stat_ev_type  ev,
   output logic                   rsp_strobe,
   output dmct_pkg::rsp_type      rsp_data
);
   import dmct_pkg::*;

   logic [COUNT_W-1:0] inst_acc_ff, inst_mis_ff, inst_rep_ff;
   logic [COUNT_W-1:0] data_acc_ff, data_mis_ff, data_rep_ff;
   logic [COUNT_W-1:0] fetch_ff, copyback_ff;
   logic [COUNT_W-1:0] cls_acc_in, cls_mis_in, cls_rep_in, fetch_in, copyback_in;
   logic [COUNT_W-1:0] words_ext;
   logic               strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   // Updated counters of the charged class and the shared word totals.
   always_comb begin
      words_ext  = {{(COUNT_W-WORDS_W){1'b0}}, ev.words};
      cls_acc_in = (ev.is_inst ? inst_acc_ff : data_acc_ff)
                   + {{(COUNT_W-1){1'b0}}, ev.acc_valid};
      cls_mis_in = (ev.is_inst ? inst_mis_ff : data_mis_ff)
                   + {{(COUNT_W-1){1'b0}}, ev.acc_valid & ~ev.hit};
      cls_rep_in = (ev.is_inst ? inst_rep_ff : data_rep_ff)
                   + {{(COUNT_W-1){1'b0}}, ev.acc_valid & ev.repl};
      fetch_in   = fetch_ff + ((ev.acc_valid && !ev.hit) ? words_ext : '0);
      copyback_in = copyback_ff
                    + (((ev.acc_valid && ev.dvict) || ev.flush_dirty) ? words_ext : '0);
   end

   // Response beat; a flush reports the data class unchanged.
   always_comb begin
      rsp_in.hit                  = ev.acc_valid & ev.hit;
      rsp_in.cold_miss            = ev.acc_valid & ev.cold;
      rsp_in.replaced             = ev.acc_valid & ev.repl;
      rsp_in.dirty_victim         = ev.acc_valid & ev.dvict;
      rsp_in.class_is_inst        = ev.is_inst;
      rsp_in.class_accesses       = cls_acc_in;
      rsp_in.class_misses         = cls_mis_in;
      rsp_in.class_replacements   = cls_rep_in;
      rsp_in.fetch_words_total    = fetch_in;
      rsp_in.copyback_words_total = copyback_in;
   end

   // Counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inst_acc_ff <= '0;
         inst_mis_ff <= '0;
         inst_rep_ff <= '0;
         data_acc_ff <= '0;
         data_mis_ff <= '0;
         data_rep_ff <= '0;
         fetch_ff    <= '0;
         copyback_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (ev.acc_valid && ev.is_inst) begin
            inst_acc_ff <= cls_acc_in;
            inst_mis_ff <= cls_mis_in;
            inst_rep_ff <= cls_rep_in;
         end
         if (ev.acc_valid && !ev.is_inst) begin
            data_acc_ff <= cls_acc_in;
            data_mis_ff <= cls_mis_in;
            data_rep_ff <= cls_rep_in;
         end
         fetch_ff    <= fetch_in;
         copyback_ff <= copyback_in;
         strobe_ff   <= ev.acc_valid | ev.flush_emit;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
